@@ design/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfr_pkg
// shared constants and types of the delimited frame receiver
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam logic [7:0] START_BYTE = 8'hFD;
  localparam logic [7:0] END_BYTE   = 8'hF8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_t;

  // one result as it leaves the parser
  typedef struct packed {
    logic       fire;
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic [7:0] address_byte;
    logic [7:0] payload_length;
  } result_t;

endpackage

@@ design/dfr_in_if.sv @@
// ----------------------------------------------------------------------------
// dfr_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/dfr_out_if.sv @@
// ----------------------------------------------------------------------------
// dfr_out_if
// result channel: payload bytes and frame verdicts, valid/ready handshake
// ----------------------------------------------------------------------------
interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] position;
  logic [7:0] address_byte;
  logic [7:0] payload_length;

  modport source (output valid, output kind, output data_byte, output position,
                  output address_byte, output payload_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input position,
                  input address_byte, input payload_length, output ready);
endinterface

@@ design/dfr_parser.sv @@
// ----------------------------------------------------------------------------
// dfr_parser
// frame state machine: header capture, payload indexing, running checksum
// ----------------------------------------------------------------------------
module dfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output dfr_pkg::result_t    res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] header_count, header_count_next;
  logic [7:0] frame_address, frame_address_next;
  logic [7:0] frame_length, frame_length_next;
  logic [8:0] byte_index, byte_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] received_check, received_check_next;
  logic [8:0] len_ext;

  assign len_ext = {1'b0, frame_length};

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    frame_address_next  = frame_address;
    frame_length_next   = frame_length;
    byte_index_next     = byte_index;
    running_sum_next    = running_sum;
    received_check_next = received_check;

    res                = '0;
    res.kind           = dfr_pkg::KIND_PAYLOAD;
    res.address_byte   = frame_address;
    res.payload_length = frame_length;

    if (rx_byte == dfr_pkg::START_BYTE) begin
      phase_next        = PH_HEADER;
      header_count_next = 2'd1;
      byte_index_next   = '0;
      running_sum_next  = '0;
    end else if (rx_byte == dfr_pkg::END_BYTE) begin
      if (phase == PH_BODY) begin
        res.fire = 1'b1;
        // early end or checksum mismatch both count as bad
        if ((byte_index == len_ext + 9'd1) && (running_sum == received_check)) begin
          res.kind = dfr_pkg::KIND_GOOD;
        end else begin
          res.kind = dfr_pkg::KIND_BAD;
        end
      end
      phase_next = PH_IDLE;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (header_count == 2'd1) begin
            frame_address_next = rx_byte;
            header_count_next  = 2'd2;
          end else begin
            frame_length_next = rx_byte;
            header_count_next = 2'd3;
            running_sum_next  = rx_byte;
            byte_index_next   = '0;
            phase_next        = PH_BODY;
          end
        end
        PH_BODY: begin
          if (byte_index < len_ext) begin
            res.fire         = 1'b1;
            res.kind         = dfr_pkg::KIND_PAYLOAD;
            res.data_byte    = rx_byte;
            res.position     = byte_index[7:0];
            running_sum_next = running_sum + rx_byte;
            byte_index_next  = byte_index + 9'd1;
          end else if (byte_index == len_ext) begin
            received_check_next = rx_byte;
            byte_index_next     = byte_index + 9'd1;
          end else begin
            // frame ran past its length
            res.fire   = 1'b1;
            res.kind   = dfr_pkg::KIND_OVERRUN;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_count   <= '0;
      frame_address  <= '0;
      frame_length   <= '0;
      byte_index     <= '0;
      running_sum    <= '0;
      received_check <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      frame_address  <= frame_address_next;
      frame_length   <= frame_length_next;
      byte_index     <= byte_index_next;
      running_sum    <= running_sum_next;
      received_check <= received_check_next;
    end
  end

endmodule

@@ design/dfr_out_reg.sv @@
// ----------------------------------------------------------------------------
// dfr_out_reg
// result register with valid/ready; refills in the cycle its content is taken
// ----------------------------------------------------------------------------
module dfr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  dfr_pkg::result_t res,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dfr_pkg::result_t held
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.fire) begin
      held <= res;
    end
  end

endmodule

@@ design/delimited_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// delimited_frame_receiver_unit
// byte-serial frame receiver: start byte, address, length, payload,
// additive checksum, end byte; emits payload bytes and frame verdicts
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | role
//  rx      | in  | rx_byte                                          | received bytes
//  res     | out | kind, data_byte, position, address_byte,         | payload / verdict
//          |     | payload_length                                   |
//
// one byte accepted per cycle while rx.ready is high; a result appears in the cycle after its byte
// the frame state and running sum update on the same accept that loads the result register
// rx.ready drops only while the result register is full and res.ready is low
// synchronous reset returns the receiver to idle and empties the result register
// ----------------------------------------------------------------------------
module delimited_frame_receiver_unit (
  input logic          clk,
  input logic          rst,
  dfr_in_if.sink       rx,
  dfr_out_if.source    res
);

  dfr_pkg::result_t parsed;
  dfr_pkg::result_t held;
  logic             in_ready;
  logic             accept;

  assign rx.ready = in_ready;
  assign accept   = rx.valid && in_ready;

  dfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .res     (parsed)
  );

  dfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .res       (parsed),
    .in_ready  (in_ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .held      (held)
  );

  assign res.kind           = held.kind;
  assign res.data_byte      = held.data_byte;
  assign res.position       = held.position;
  assign res.address_byte   = held.address_byte;
  assign res.payload_length = held.payload_length;

endmodule

@@ test/dfr_frame_check.sv @@
// ----------------------------------------------------------------------------
// dfr_frame_check
// watches the byte and result channels of the frame receiver, predicts the
// payload bytes and frame verdicts for every accepted byte and compares them
// in order with the results that the receiver hands out
// ----------------------------------------------------------------------------
module dfr_frame_check (
  input  logic clk,
  input  logic rst,
  dfr_in_if    rx,
  dfr_out_if   res,
  output int   failures,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RX_IDLE   = 2'd0,
    RX_HEADER = 2'd1,
    RX_BODY   = 2'd2
  } rx_phase_t;

  typedef struct packed {
    dfr_pkg::kind_t kind;
    logic [7:0]     data_byte;
    logic [7:0]     position;
    logic [7:0]     address_byte;
    logic [7:0]     payload_length;
  } frame_event_t;

  frame_event_t frame_events[$];

  rx_phase_t  phase;
  logic [1:0] header_count;
  logic [7:0] frame_address;
  logic [7:0] frame_length;
  logic [8:0] byte_index;
  logic [7:0] running_sum;
  logic [7:0] received_check;

  task push_event(input dfr_pkg::kind_t kind, input logic [7:0] data,
                  input logic [7:0] pos);
    frame_event_t ev;
    ev.kind           = kind;
    ev.data_byte      = data;
    ev.position       = pos;
    ev.address_byte   = frame_address;
    ev.payload_length = frame_length;
    frame_events.push_back(ev);
  endtask

  task track_byte(input logic [7:0] b);
    if (b == dfr_pkg::START_BYTE) begin
      // a start byte restarts reception from any state
      phase        = RX_HEADER;
      header_count = 2'd1;
      byte_index   = '0;
      running_sum  = '0;
    end else if (b == dfr_pkg::END_BYTE) begin
      if (phase == RX_BODY) begin
        if (byte_index == {1'b0, frame_length} + 9'd1 && running_sum == received_check)
          push_event(dfr_pkg::KIND_GOOD, 8'h00, 8'h00);
        else
          push_event(dfr_pkg::KIND_BAD, 8'h00, 8'h00);
      end
      phase = RX_IDLE;
    end else if (phase == RX_HEADER) begin
      if (header_count == 2'd1) begin
        frame_address = b;
        header_count  = 2'd2;
      end else begin
        frame_length = b;
        header_count = 2'd3;
        running_sum  = b;
        byte_index   = '0;
        phase        = RX_BODY;
      end
    end else if (phase == RX_BODY) begin
      if (byte_index < {1'b0, frame_length}) begin
        running_sum = running_sum + b;
        push_event(dfr_pkg::KIND_PAYLOAD, b, byte_index[7:0]);
        byte_index = byte_index + 9'd1;
      end else if (byte_index == {1'b0, frame_length}) begin
        received_check = b;
        byte_index     = byte_index + 9'd1;
      end else begin
        push_event(dfr_pkg::KIND_OVERRUN, 8'h00, 8'h00);
        phase = RX_IDLE;
      end
    end else begin
      phase = RX_IDLE;
    end
  endtask

  always @(posedge clk) begin
    frame_event_t got;
    frame_event_t want;
    if (rst) begin
      phase          = RX_IDLE;
      header_count   = '0;
      frame_address  = '0;
      frame_length   = '0;
      byte_index     = '0;
      running_sum    = '0;
      received_check = '0;
      frame_events.delete();
      failures = 0;
    end else begin
      // a result always trails its byte, so check before predicting
      if (res.valid && res.ready) begin
        got.kind           = dfr_pkg::kind_t'(res.kind);
        got.data_byte      = res.data_byte;
        got.position       = res.position;
        got.address_byte   = res.address_byte;
        got.payload_length = res.payload_length;
        if (frame_events.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%t unexpected result: kind=%0d data=%02h pos=%0d addr=%02h len=%0d",
                     $realtime, got.kind, got.data_byte, got.position,
                     got.address_byte, got.payload_length);
        end else begin
          want = frame_events.pop_front();
          if (got != want) begin
            failures++;
            if (failures <= 10)
              $display({"%t mismatch: expected kind=%0d data=%02h pos=%0d addr=%02h len=%0d,",
                        " got kind=%0d data=%02h pos=%0d addr=%02h len=%0d"},
                       $realtime, want.kind, want.data_byte, want.position,
                       want.address_byte, want.payload_length, got.kind, got.data_byte,
                       got.position, got.address_byte, got.payload_length);
          end
        end
      end
      if (rx.valid && rx.ready)
        track_byte(rx.rx_byte);
    end
    pending = frame_events.size();
  end

endmodule

@@ test/delimited_frame_receiver_unit_test.sv @@
// ----------------------------------------------------------------------------
// delimited_frame_receiver_unit_test
// drives directed and random byte streams of well-formed and broken frames
// into the receiver with random gaps and result stalls; the frame checker
// beside the block compares every result and reports the failure count
// ----------------------------------------------------------------------------
module delimited_frame_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TOTAL = 1400;
  localparam int QUIET_TAIL  = 200;
  localparam int STALL_LIMIT = 500;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_SUM,
    FLAW_EARLY_END,
    FLAW_OVERRUN,
    FLAW_CUT_SHORT
  } frame_flaw_t;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   bytes_sent;
  int   idle_cycles;
  int   stall_left;
  bit   idling;

  dfr_in_if  rx();
  dfr_out_if res();

  delimited_frame_receiver_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res)
  );

  dfr_frame_check u_frame_check (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .res      (res),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stall bursts while idling is on
  initial begin
    res.ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res.ready = 1'b0;
        stall_left--;
      end else begin
        res.ready = 1'b1;
        if (idling && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((rx.valid && rx.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == dfr_pkg::START_BYTE || b == dfr_pkg::END_BYTE);
    return b;
  endfunction

  // mostly plain bytes, now and then a start or end byte inside the frame
  function automatic logic [7:0] body_byte();
    if ($urandom_range(0, 99) < 3)
      return 8'($urandom_range(0, 255));
    return plain_byte();
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    if (idling && $urandom_range(0, 7) == 0) begin
      rx.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    rx.valid   = 1'b1;
    rx.rx_byte = b;
    do @(posedge clk);
    while (!rx.ready);
    @(negedge clk);
    if (counted)
      bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input int len, input frame_flaw_t flaw);
    logic [7:0] sum;
    logic [7:0] b;
    int         cut;
    sum = 8'(len);
    cut = (flaw == FLAW_CUT_SHORT) ? $urandom_range(0, len + 1) : $urandom_range(0, len);
    send_byte(dfr_pkg::START_BYTE);
    send_byte(addr);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == cut && flaw == FLAW_EARLY_END) begin
        send_byte(dfr_pkg::END_BYTE);
        return;
      end
      if (i == cut && flaw == FLAW_CUT_SHORT)
        return;
      b   = body_byte();
      sum = sum + b;
      send_byte(b);
    end
    // end byte in place of the checksum
    if (flaw == FLAW_EARLY_END) begin
      send_byte(dfr_pkg::END_BYTE);
      return;
    end
    if (flaw == FLAW_CUT_SHORT && cut == len)
      return;
    send_byte(flaw == FLAW_BAD_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
    if (flaw == FLAW_CUT_SHORT)
      return;
    send_byte(flaw == FLAW_OVERRUN ? plain_byte() : dfr_pkg::END_BYTE);
  endtask

  task automatic wait_drained();
    rx.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0]  directed_bytes[$];
    frame_flaw_t flaw;
    int          frame_no;
    int          len;
    int          pick;
    directed_bytes = '{
      dfr_pkg::END_BYTE, 8'h00,                                 // ignored while idle
      dfr_pkg::START_BYTE, 8'h55, 8'h02, 8'h10,                 // restarted by the next start
      dfr_pkg::START_BYTE, 8'hFF, 8'h00, 8'h00,
      dfr_pkg::END_BYTE,                                        // empty payload, good
      dfr_pkg::START_BYTE, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h01,
      dfr_pkg::END_BYTE,                                        // good
      dfr_pkg::START_BYTE, 8'h11, 8'h00, 8'h05,
      dfr_pkg::END_BYTE,                                        // checksum mismatch
      dfr_pkg::START_BYTE, 8'h22, 8'h03, 8'h01,
      dfr_pkg::END_BYTE,                                        // early end
      dfr_pkg::START_BYTE, 8'h33, 8'h00, 8'h00, 8'h55,          // overrun
      dfr_pkg::START_BYTE, 8'h44, dfr_pkg::END_BYTE             // end inside header
    };
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = 8'h00;
    idling     = 1'b1;
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);
    wait_drained();

    frame_no = 0;
    while (bytes_sent < ITEMS_TOTAL) begin
      if (bytes_sent > ITEMS_TOTAL - QUIET_TAIL)
        idling = 1'b0;
      if (frame_no == 40)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (frame_no == 12 || frame_no == 55)
        len = 255;
      else if (pick < 70)
        len = $urandom_range(0, 6);
      else
        len = $urandom_range(7, 40);
      pick = $urandom_range(0, 99);
      if (frame_no == 12 || pick < 65)
        flaw = FLAW_NONE;
      else if (pick < 75)
        flaw = FLAW_BAD_SUM;
      else if (pick < 83)
        flaw = FLAW_EARLY_END;
      else if (pick < 90)
        flaw = FLAW_OVERRUN;
      else
        flaw = FLAW_CUT_SHORT;
      send_frame($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : plain_byte(),
                 len, flaw);
      // line noise between frames
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 4))
          send_byte($urandom_range(0, 1) ? dfr_pkg::END_BYTE : plain_byte(), 1'b0);
      frame_no++;
    end

    rx.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
